[src/apd_pkg.sv]
package apd_pkg;

    localparam int CNT_W      = 13;
    localparam int OUT_CNT_W  = 14;
    localparam int RATIO_W    = 18;
    localparam int FRAC_W     = 16;
    localparam int CHAR_W     = 8;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    // dividend is diff << 16, one quotient bit per step
    localparam int DIV_STEPS = CNT_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [RATIO_W-1:0] RATIO_MAX = 18'd131072;

    localparam logic [CHAR_W-1:0] GAP_CH = 8'h2D;
    localparam logic [CHAR_W-1:0] N_CH   = 8'h4E;
    localparam logic [CHAR_W-1:0] DOT_CH = 8'h2E;

    // configuration register indexes
    localparam logic CFG_MODE_PLAIN = 1'b0;
    localparam logic CFG_TRIM_ENDS  = 1'b1;

    typedef struct packed {
        logic col_take;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v != CNT_MAX) ? v + 1'b1 : CNT_MAX;
    endfunction

endpackage

[src/apd_ctrl.sv]
module apd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tlast,
    input  logic             i_m_tready,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    output apd_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] S_COLLECT = 2'd0;
    localparam logic [1:0] S_DIV     = 2'd1;
    localparam logic [1:0] S_HOLD    = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [apd_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;
    logic                        s_accept;
    logic                        slot_free;

    assign o_s_tready = (r_state == S_COLLECT);
    assign o_m_tvalid = r_out_valid;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign slot_free  = !r_out_valid || i_m_tready;

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_cmd.col_take = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_COLLECT: begin
                if (s_accept) begin
                    o_cmd.col_take = 1'b1;
                    if (i_s_tlast) begin
                        n_state = S_DIV;
                        n_cnt   = '0;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == apd_pkg::DIV_CNT_W'(apd_pkg::DIV_STEPS - 1)) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_COLLECT;
                end
            end
            default: n_state = S_COLLECT;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[src/apd_dp.sv]
module apd_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic                             i_cfg_index,
    input  logic                             i_cfg_wdata,
    input  logic [apd_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input  logic                             i_s_tlast,
    input  apd_pkg::t_dp_cmd                 i_cmd,
    output logic [apd_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic                             o_m_tuser
);

    localparam int CW = apd_pkg::CNT_W;
    localparam int DW = apd_pkg::DIV_STEPS;

    logic r_mode_plain;
    logic r_trim;

    // per-alignment state
    logic [CW-1:0]   r_dist, n_dist;
    logic [CW-1:0]   r_res, n_res;
    logic            r_qgap, n_qgap;
    logic            r_sgap, n_sgap;
    logic            r_seen_q, n_seen_q;
    logic            r_seen_s, n_seen_s;
    logic [2*CW-1:0] r_snap_q, n_snap_q;
    logic [2*CW-1:0] r_snap_s, n_snap_s;
    logic            r_q_latest, n_q_latest;
    logic [CW-1:0]   r_qlen, n_qlen;
    logic [CW-1:0]   r_slen, n_slen;
    logic [CW-1:0]   r_plain, n_plain;

    // divider
    logic [CW-1:0] r_div_den;
    logic [CW-1:0] r_div_diff;
    logic [CW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [CW:0]   trial;
    logic          q_bit;

    logic [apd_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                           r_out_user;

    logic [apd_pkg::CHAR_W-1:0] q_ch, s_ch;
    logic                       q_res, s_res;
    logic                       collapse_en;
    logic [2*CW-1:0]            snap_sel;
    logic [CW-1:0]              fin_diff, fin_den;
    logic                       den_nz;
    logic [apd_pkg::RATIO_W-1:0] ratio;

    assign q_ch  = i_s_tdata[7:0];
    assign s_ch  = i_s_tdata[15:8];
    assign q_res = (q_ch != apd_pkg::GAP_CH);
    assign s_res = (s_ch != apd_pkg::GAP_CH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_plain <= 1'b0;
            r_trim       <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                apd_pkg::CFG_MODE_PLAIN: r_mode_plain <= i_cfg_wdata;
                apd_pkg::CFG_TRIM_ENDS:  r_trim       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_plain = r_plain;
        if (q_ch != s_ch || !q_res || !s_res) begin
            n_plain = apd_pkg::sat_inc(r_plain);
        end
        n_qlen   = q_res ? apd_pkg::sat_inc(r_qlen) : r_qlen;
        n_slen   = s_res ? apd_pkg::sat_inc(r_slen) : r_slen;
        n_seen_q = r_seen_q | q_res;
        n_seen_s = r_seen_s | s_res;
        collapse_en = !r_trim || (n_seen_q && n_seen_s);

        n_dist = r_dist;
        n_res  = r_res;
        n_qgap = r_qgap;
        n_sgap = r_sgap;
        if (collapse_en) begin
            if (!q_res && !s_res) begin
                // both gap: skipped
            end else if ((q_ch == apd_pkg::N_CH && s_ch == apd_pkg::N_CH) ||
                         (q_ch == apd_pkg::DOT_CH && s_ch == apd_pkg::DOT_CH)) begin
                n_qgap = 1'b0;
                n_sgap = 1'b0;
            end else if (!q_res) begin
                if (!r_qgap) begin
                    n_res  = apd_pkg::sat_inc(r_res);
                    n_dist = apd_pkg::sat_inc(r_dist);
                end
                n_qgap = 1'b1;
                n_sgap = 1'b0;
            end else if (!s_res) begin
                if (!r_sgap) begin
                    n_res  = apd_pkg::sat_inc(r_res);
                    n_dist = apd_pkg::sat_inc(r_dist);
                end
                n_qgap = 1'b0;
                n_sgap = 1'b1;
            end else begin
                if (q_ch != s_ch) begin
                    n_dist = apd_pkg::sat_inc(r_dist);
                end
                n_res  = apd_pkg::sat_inc(r_res);
                n_qgap = 1'b0;
                n_sgap = 1'b0;
            end
        end

        n_snap_q = q_res ? {n_dist, n_res} : r_snap_q;
        n_snap_s = s_res ? {n_dist, n_res} : r_snap_s;
        n_q_latest = r_q_latest;
        if (q_res && !s_res) begin
            n_q_latest = 1'b1;
        end else if (s_res && !q_res) begin
            n_q_latest = 1'b0;
        end

        snap_sel = n_q_latest ? n_snap_s : n_snap_q;
        if (r_mode_plain) begin
            fin_diff = n_plain;
            fin_den  = (n_qlen > n_slen) ? n_qlen : n_slen;
        end else if (r_trim) begin
            if (n_seen_q && n_seen_s) begin
                fin_diff = snap_sel[2*CW-1:CW];
                fin_den  = snap_sel[CW-1:0];
            end else begin
                fin_diff = '0;
                fin_den  = '0;
            end
        end else begin
            fin_diff = n_dist;
            fin_den  = n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist     <= '0;
            r_res      <= '0;
            r_qgap     <= 1'b0;
            r_sgap     <= 1'b0;
            r_seen_q   <= 1'b0;
            r_seen_s   <= 1'b0;
            r_snap_q   <= '0;
            r_snap_s   <= '0;
            r_q_latest <= 1'b0;
            r_qlen     <= '0;
            r_slen     <= '0;
            r_plain    <= '0;
        end else if (i_cmd.col_take) begin
            if (i_s_tlast) begin
                r_dist     <= '0;
                r_res      <= '0;
                r_qgap     <= 1'b0;
                r_sgap     <= 1'b0;
                r_seen_q   <= 1'b0;
                r_seen_s   <= 1'b0;
                r_snap_q   <= '0;
                r_snap_s   <= '0;
                r_q_latest <= 1'b0;
                r_qlen     <= '0;
                r_slen     <= '0;
                r_plain    <= '0;
            end else begin
                r_dist     <= n_dist;
                r_res      <= n_res;
                r_qgap     <= n_qgap;
                r_sgap     <= n_sgap;
                r_seen_q   <= n_seen_q;
                r_seen_s   <= n_seen_s;
                r_snap_q   <= n_snap_q;
                r_snap_s   <= n_snap_s;
                r_q_latest <= n_q_latest;
                r_qlen     <= n_qlen;
                r_slen     <= n_slen;
                r_plain    <= n_plain;
            end
        end
    end

    // restoring division, one quotient bit per step
    assign trial = {r_rem, r_quo[DW-1]};
    assign q_bit = (trial >= {1'b0, r_div_den});

    always_ff @(posedge i_clk) begin
        if (i_cmd.col_take && i_s_tlast) begin
            r_div_den  <= fin_den;
            r_div_diff <= fin_diff;
            r_rem      <= '0;
            r_quo      <= {fin_diff, {apd_pkg::FRAC_W{1'b0}}};
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? CW'(trial - {1'b0, r_div_den}) : trial[CW-1:0];
            r_quo <= {r_quo[DW-2:0], q_bit};
        end
    end

    assign den_nz = (r_div_den != '0);

    always_comb begin
        if (!den_nz) begin
            ratio = '0;
        end else if (r_quo > DW'(apd_pkg::RATIO_MAX)) begin
            ratio = apd_pkg::RATIO_MAX;
        end else begin
            ratio = r_quo[apd_pkg::RATIO_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {2'b00, ratio, 1'b0, r_div_den, 1'b0, r_div_diff};
            r_out_user <= den_nz;
        end
    end

    assign o_m_tdata = r_out_data;
    assign o_m_tuser = r_out_user;

endmodule

[src/aligned_pair_distance.sv]
// channel   dir  handshake             payload
// s (cols)  in   i_s_tvalid/o_s_tready tdata {subject_char, query_char}, tlast last_column
// m (res)   out  o_m_tvalid/i_m_tready tdata {ratio_q16, denominator, diff_count}, tuser valid
// cfg       in   i_cfg_wr_en           i_cfg_index, i_cfg_wdata
//
// a column that is not the last is taken back to back
// the last column starts a 29-step restoring divider (one quotient bit per
// cycle), then S_HOLD loads the output register; no column is taken until
// that load, which waits while the output register is still full
// columns keep streaming while a result waits to be taken
// synchronous active-low reset clears counters and sets trim_end_gaps
module aligned_pair_distance (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_index,
    input  logic                            i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [7:0] query_char, [15:8] subject_char
    input  logic [apd_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [13:0] diff_count, [27:14] denominator, [45:28] ratio_q16, [47:46] zero
    output logic [apd_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // [0] result_valid
    output logic                            o_m_tuser
);

    apd_pkg::t_dp_cmd cmd;

    apd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .i_m_tready (i_m_tready),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    apd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_cmd       (cmd),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // the last column hands over to the divider, no column taken next cycle
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("column taken right after last column");

    a_valid_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (!o_m_tuser || (o_m_tdata[27:14] != 14'd0)))
        else $error("result flagged valid with zero denominator");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[45:28] == 18'd0))
        else $error("invalid result with nonzero ratio");

    a_ratio_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[45:28] <= apd_pkg::RATIO_MAX))
        else $error("ratio above saturation limit");

endmodule
